[design/fan_stall_restart_control_defines.svh]
// Assertion macros used by the fan stall restart control RTL.
`ifndef FAN_STALL_RESTART_CONTROL_DEFINES_SVH
`define FAN_STALL_RESTART_CONTROL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FSRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FSRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fsrc_pkg.sv]
// Types and constants for the fan stall restart control block.
package fsrc_pkg;

    localparam int COUNT_WIDTH = 24;   // elapsed / quiet counter width, 8..32
    localparam int TICKS_WIDTH = 24;
    localparam int DUTY_WIDTH  = 8;
    localparam int CMP_WIDTH   = 32;   // common width for counter/threshold compares

    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 5;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [TICKS_WIDTH-1:0] ticks_t;
    typedef logic [DUTY_WIDTH-1:0]  duty_t;
    typedef logic [1:0]             mode_t;
    typedef logic [2:0]             reg_idx_t;

    localparam mode_t MODE_LAUNCH = 2'd0;
    localparam mode_t MODE_START  = 2'd1;
    localparam mode_t MODE_RUN    = 2'd2;
    localparam mode_t MODE_WAIT   = 2'd3;

    localparam reg_idx_t REG_STARTUP_DUTY  = 3'd0;
    localparam reg_idx_t REG_STARTUP_TICKS = 3'd1;
    localparam reg_idx_t REG_STALL_TICKS   = 3'd2;
    localparam reg_idx_t REG_RETRY_TICKS   = 3'd3;
    localparam reg_idx_t REG_MIN_DUTY      = 3'd4;

    localparam duty_t  RST_STARTUP_DUTY  = 8'd200;
    localparam ticks_t RST_STARTUP_TICKS = 24'd37500;
    localparam ticks_t RST_STALL_TICKS   = 24'd9375;
    localparam ticks_t RST_RETRY_TICKS   = 24'd37500;
    localparam duty_t  RST_MIN_DUTY      = 8'd40;

    typedef struct packed {
        duty_t  startup_duty;
        ticks_t startup_ticks;
        ticks_t stall_ticks;
        ticks_t retry_ticks;
        duty_t  min_duty;
    } cfg_t;

    typedef struct packed {
        logic  tick;
        logic  tach_edge;
        duty_t pot_level;
    } in_data_t;

    typedef struct packed {
        duty_t duty;
        mode_t mode;
    } out_data_t;

    typedef struct packed {
        mode_t mode;
        cnt_t  elapsed_count;
        cnt_t  quiet_count;
        logic  stall_seen;
        duty_t applied_duty;
        duty_t restart_duty;
    } state_t;

endpackage

[design/fsrc_in_if.sv]
// Input channel: tick, tach edge and pot level with valid/ready.
interface fsrc_in_if;
    import fsrc_pkg::*;

    logic  valid;
    logic  ready;
    logic  tick;
    logic  tach_edge;
    duty_t pot_level;

    modport source (output valid, output tick, output tach_edge, output pot_level,
                    input ready);
    modport sink   (input valid, input tick, input tach_edge, input pot_level,
                    output ready);
endinterface

[design/fsrc_out_if.sv]
// Result channel: applied duty and mode with valid/ready.
interface fsrc_out_if;
    import fsrc_pkg::*;

    logic  valid;
    logic  ready;
    duty_t duty;
    mode_t mode;

    modport source (output valid, output duty, output mode, input ready);
    modport sink   (input valid, input duty, input mode, output ready);
endinterface

[design/fan_stall_restart_control.sv]
// Top level of the fan stall restart control block.
// Fan drive sequencer: one result transaction per input transaction, one
// transaction per clock sustained while out_ch is ready. The input register
// takes the transaction; the sequencer state and result register then load
// from it. in_ch.ready stays high unless both registers are full and out_ch
// is stalled. The state update loop (counter increment, threshold compares,
// mode select) is combinational. Config registers are written over APB at
// byte address 4*index only while idle: a user rule the block does not enforce.
`include "fan_stall_restart_control_defines.svh"

module fan_stall_restart_control (
    input  logic                                clk,
    input  logic                                rst_n,
    fsrc_in_if.sink                             in_ch,
    fsrc_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fsrc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [fsrc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [fsrc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready
);
    import fsrc_pkg::*;

    cfg_t      cfg;
    in_data_t  in_data_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_data_t out_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    state_t    state_reg;
    state_t    state_next;
    logic      fire;
    logic      in_take;

    fsrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fsrc_step u_step (
        .cfg       (cfg),
        .state_cur (state_reg),
        .item      (in_data_reg),
        .state_upd (state_next)
    );

    // process the held transaction when the result slot is free or draining
    assign fire         = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || fire;
    assign in_take      = in_ch.valid && in_ch.ready;

    assign in_valid_next  = in_take || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !out_ch.ready);

    assign out_ch.valid = out_valid_reg;
    assign out_ch.duty  = out_data_reg.duty;
    assign out_ch.mode  = out_data_reg.mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg.tick      <= in_ch.tick;
            in_data_reg.tach_edge <= in_ch.tach_edge;
            in_data_reg.pot_level <= in_ch.pot_level;
        end
        if (fire)
        begin
            out_data_reg.duty <= state_next.applied_duty;
            out_data_reg.mode <= state_next.mode;
        end
    end

    `FSRC_ASSERT_NOW(a_wait_drive_off, out_valid_reg && out_data_reg.mode == MODE_WAIT,
        out_data_reg.duty == '0, "drive not off in stall wait")
    `FSRC_ASSERT_NOW(a_no_launch_result, out_valid_reg,
        out_data_reg.mode != MODE_LAUNCH, "result reports launch mode")
    `FSRC_ASSERT_NEXT(a_launch_once, state_reg.mode != MODE_LAUNCH,
        state_reg.mode != MODE_LAUNCH, "sequencer returned to launch")
    `FSRC_ASSERT_NEXT(a_held_item_kept, in_valid_reg && !fire,
        in_valid_reg && $stable(in_data_reg) && $stable(state_reg),
        "held transaction or state changed while stalled")

endmodule

[design/fsrc_cfg.sv]
// APB configuration registers for the fan stall restart control block.
module fsrc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fsrc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [fsrc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [fsrc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output fsrc_pkg::cfg_t                      cfg
);
    import fsrc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = paddr[APB_ADDR_WIDTH-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_STARTUP_DUTY:  cfg_next.startup_duty  = pwdata[DUTY_WIDTH-1:0];
                REG_STARTUP_TICKS: cfg_next.startup_ticks = pwdata[TICKS_WIDTH-1:0];
                REG_STALL_TICKS:   cfg_next.stall_ticks   = pwdata[TICKS_WIDTH-1:0];
                REG_RETRY_TICKS:   cfg_next.retry_ticks   = pwdata[TICKS_WIDTH-1:0];
                REG_MIN_DUTY:      cfg_next.min_duty      = pwdata[DUTY_WIDTH-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STARTUP_DUTY:  prdata = APB_DATA_WIDTH'(cfg_reg.startup_duty);
            REG_STARTUP_TICKS: prdata = APB_DATA_WIDTH'(cfg_reg.startup_ticks);
            REG_STALL_TICKS:   prdata = APB_DATA_WIDTH'(cfg_reg.stall_ticks);
            REG_RETRY_TICKS:   prdata = APB_DATA_WIDTH'(cfg_reg.retry_ticks);
            REG_MIN_DUTY:      prdata = APB_DATA_WIDTH'(cfg_reg.min_duty);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_duty  <= RST_STARTUP_DUTY;
            cfg_reg.startup_ticks <= RST_STARTUP_TICKS;
            cfg_reg.stall_ticks   <= RST_STALL_TICKS;
            cfg_reg.retry_ticks   <= RST_RETRY_TICKS;
            cfg_reg.min_duty      <= RST_MIN_DUTY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/fsrc_step.sv]
// Per-transaction state update: counters, stall detect, kick and mode sequencing.
module fsrc_step (
    input  fsrc_pkg::cfg_t     cfg,
    input  fsrc_pkg::state_t   state_cur,
    input  fsrc_pkg::in_data_t item,
    output fsrc_pkg::state_t   state_upd
);
    import fsrc_pkg::*;

    localparam cnt_t CNT_MAX = '1;

    state_t s;
    duty_t  want;
    duty_t  kick_want;
    logic   do_kick;

    always_comb
    begin
        s         = state_cur;
        want      = (item.pot_level < cfg.min_duty) ? cfg.min_duty : item.pot_level;
        do_kick   = 1'b0;
        kick_want = item.pot_level;

        if (state_cur.mode == MODE_LAUNCH)
        begin
            do_kick = 1'b1;
        end
        else
        begin
            // edge is applied before the tick
            if (item.tach_edge)
            begin
                s.quiet_count = '0;
            end
            if (item.tick)
            begin
                if (s.elapsed_count != CNT_MAX)
                begin
                    s.elapsed_count = s.elapsed_count + 1'b1;
                end
                if (CMP_WIDTH'(s.quiet_count) < CMP_WIDTH'(cfg.stall_ticks))
                begin
                    if (s.quiet_count != CNT_MAX)
                    begin
                        s.quiet_count = s.quiet_count + 1'b1;
                    end
                end
                else
                begin
                    s.stall_seen = 1'b1;
                end
                if (s.mode == MODE_START &&
                    CMP_WIDTH'(s.elapsed_count) > CMP_WIDTH'(cfg.startup_ticks))
                begin
                    s.mode = MODE_RUN;
                end
            end
            if (s.mode == MODE_WAIT)
            begin
                if (CMP_WIDTH'(s.elapsed_count) > CMP_WIDTH'(cfg.retry_ticks))
                begin
                    do_kick   = 1'b1;
                    kick_want = s.restart_duty;
                end
            end
            else
            begin
                if (s.mode == MODE_RUN)
                begin
                    s.applied_duty = want;
                end
                if (s.stall_seen)
                begin
                    s.applied_duty  = '0;
                    s.elapsed_count = '0;
                    s.restart_duty  = want;
                    s.mode          = MODE_WAIT;
                end
            end
        end

        if (do_kick)
        begin
            s.applied_duty  = (kick_want < cfg.startup_duty) ? cfg.startup_duty : kick_want;
            s.stall_seen    = 1'b0;
            s.quiet_count   = '0;
            s.elapsed_count = '0;
            s.mode          = MODE_START;
        end

        state_upd = s;
    end

endmodule

[tb/tb_fan_stall_restart_control.sv]
// Testbench for fan_stall_restart_control: directed and random traffic, APB setup, scoreboard.
module tb_fan_stall_restart_control;
    import fsrc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned NUM_PHASES      = 12;
    localparam int unsigned PHASE_ITEMS     = 88;
    localparam ticks_t      TICKS_MAX       = '1;

    // Predicts the applied duty and mode for every accepted input transaction.
    class fan_drive_scoreboard;
        cfg_t        cfg;
        state_t      st;
        out_data_t   expected_q[$];
        int unsigned mismatches;

        function new();
            cfg.startup_duty  = RST_STARTUP_DUTY;
            cfg.startup_ticks = RST_STARTUP_TICKS;
            cfg.stall_ticks   = RST_STALL_TICKS;
            cfg.retry_ticks   = RST_RETRY_TICKS;
            cfg.min_duty      = RST_MIN_DUTY;
            st                = '0;
            st.mode           = MODE_LAUNCH;
            mismatches        = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_STARTUP_DUTY:  cfg.startup_duty  = value[DUTY_WIDTH-1:0];
                REG_STARTUP_TICKS: cfg.startup_ticks = value[TICKS_WIDTH-1:0];
                REG_STALL_TICKS:   cfg.stall_ticks   = value[TICKS_WIDTH-1:0];
                REG_RETRY_TICKS:   cfg.retry_ticks   = value[TICKS_WIDTH-1:0];
                REG_MIN_DUTY:      cfg.min_duty      = value[DUTY_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function void kick_fan(duty_t level);
            st.applied_duty  = (level < cfg.startup_duty) ? cfg.startup_duty : level;
            st.stall_seen    = 1'b0;
            st.quiet_count   = '0;
            st.elapsed_count = '0;
            st.mode          = MODE_START;
        endfunction

        function void note_input(in_data_t item);
            duty_t     clamped;
            out_data_t want;
            clamped = (item.pot_level < cfg.min_duty) ? cfg.min_duty : item.pot_level;
            if (st.mode == MODE_LAUNCH)
            begin
                kick_fan(item.pot_level);
            end
            else
            begin
                // tach edge is applied before the tick
                if (item.tach_edge)
                    st.quiet_count = '0;
                if (item.tick)
                begin
                    if (st.elapsed_count != '1)
                        st.elapsed_count++;
                    if (st.quiet_count < cfg.stall_ticks)
                    begin
                        if (st.quiet_count != '1)
                            st.quiet_count++;
                    end
                    else
                    begin
                        st.stall_seen = 1'b1;
                    end
                    if (st.mode == MODE_START && st.elapsed_count > cfg.startup_ticks)
                        st.mode = MODE_RUN;
                end
                if (st.mode == MODE_WAIT)
                begin
                    if (st.elapsed_count > cfg.retry_ticks)
                        kick_fan(st.restart_duty);
                end
                else
                begin
                    if (st.mode == MODE_RUN)
                        st.applied_duty = clamped;
                    if (st.stall_seen)
                    begin
                        st.applied_duty  = '0;
                        st.elapsed_count = '0;
                        st.restart_duty  = clamped;
                        st.mode          = MODE_WAIT;
                    end
                end
            end
            want.duty = st.applied_duty;
            want.mode = st.mode;
            expected_q.push_back(want);
        endfunction

        function void check_result(out_data_t got);
            out_data_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: duty %0d mode %0d", got.duty, got.mode);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.duty !== want.duty)
            begin
                $error("duty mismatch: expected %0d, actual %0d", want.duty, got.duty);
                mismatches++;
            end
            if (got.mode !== want.mode)
            begin
                $error("mode mismatch: expected %0d, actual %0d", want.mode, got.mode);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      rx_hold;
    int unsigned               tx_idle_pct;
    int unsigned               rx_stall_pct;
    int unsigned               cfg_errors;
    int unsigned               cycle_count = 0;
    fan_drive_scoreboard       sb;

    fsrc_in_if  in_ch();
    fsrc_out_if out_ch();

    fan_stall_restart_control uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check accepted transactions, then pick next ready.
    always @(posedge clk)
    begin
        out_data_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.duty = out_ch.duty;
                got.mode = out_ch.mode;
                sb.check_result(got);
            end
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input in_data_t item);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.tick      <= item.tick;
        in_ch.tach_edge <= item.tach_edge;
        in_ch.pot_level <= item.pot_level;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_input(item);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write followed by a readback of the same register.
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus goes idle before the next access
        @(posedge clk);
        if (readback !== value)
        begin
            $error("register %0d readback: expected %0h, actual %0h", idx, value, readback);
            cfg_errors++;
        end
    endtask

    task automatic apply_setting(input duty_t s_duty, input ticks_t s_ticks,
                                 input ticks_t q_ticks, input ticks_t r_ticks,
                                 input duty_t m_duty);
        drain();
        cfg_write(REG_STARTUP_DUTY, 32'(s_duty));
        cfg_write(REG_STARTUP_TICKS, 32'(s_ticks));
        cfg_write(REG_STALL_TICKS, 32'(q_ticks));
        cfg_write(REG_RETRY_TICKS, 32'(r_ticks));
        cfg_write(REG_MIN_DUTY, 32'(m_duty));
    endtask

    function automatic in_data_t random_item(int unsigned tick_pct, int unsigned edge_pct);
        in_data_t item;
        item.tick      = ($urandom_range(99) < tick_pct);
        item.tach_edge = ($urandom_range(99) < edge_pct);
        case ($urandom_range(9))
            0:       item.pot_level = '0;
            1:       item.pot_level = '1;
            default: item.pot_level = duty_t'($urandom_range(255));
        endcase
        return item;
    endfunction

    function automatic duty_t pick_duty(int unsigned phase, int unsigned sel);
        case ((phase + sel) % 4)
            0:       return '0;
            1:       return '1;
            default: return duty_t'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        int unsigned tick_pct;
        int unsigned edge_pct;
        ticks_t      s_ticks;
        ticks_t      q_ticks;
        ticks_t      r_ticks;

        sb           = new();
        cfg_errors   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.tick      = 1'b0;
        in_ch.tach_edge = 1'b0;
        in_ch.pot_level = '0;
        out_ch.ready    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // launch item ignores tick and edge; then the kick phase at reset settings
        send_item({1'b1, 1'b1, 8'hFF});
        send_item({1'b0, 1'b0, 8'h00});
        send_item({1'b1, 1'b0, 8'h00});
        send_item({1'b0, 1'b1, 8'hFF});
        send_item({1'b1, 1'b1, 8'h80});
        send_item({1'b1, 1'b0, 8'hFF});

        // running with clamp at max, stall, immediate restart
        apply_setting(8'd0, 24'd0, 24'd2, 24'd0, 8'd255);
        send_item({1'b1, 1'b1, 8'h10});
        send_item({1'b1, 1'b0, 8'h00});
        send_item({1'b0, 1'b0, 8'h00});
        send_item({1'b1, 1'b0, 8'h7F});
        send_item({1'b0, 1'b1, 8'h00});
        send_item({1'b1, 1'b0, 8'h00});
        send_item({1'b1, 1'b1, 8'h00});

        // zero stall time: stall from running and from starting, boosted restart
        apply_setting(8'd255, TICKS_MAX, 24'd0, 24'd3, 8'd0);
        send_item({1'b1, 1'b1, 8'h00});
        send_item({1'b1, 1'b0, 8'h40});
        send_item({1'b0, 1'b0, 8'h40});
        send_item({1'b1, 1'b0, 8'h40});
        send_item({1'b1, 1'b0, 8'h40});
        send_item({1'b1, 1'b1, 8'hFF});
        send_item({1'b1, 1'b0, 8'hFF});

        for (int unsigned phase = 0; phase < NUM_PHASES; phase++)
        begin
            s_ticks = (phase == 3) ? TICKS_MAX : ticks_t'($urandom_range(12));
            q_ticks = (phase == 6) ? TICKS_MAX : ticks_t'($urandom_range(8));
            r_ticks = (phase == 9) ? TICKS_MAX : ticks_t'($urandom_range(12));
            apply_setting(pick_duty(phase, 0), s_ticks, q_ticks, r_ticks,
                          pick_duty(phase, 2));
            case (phase % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 48;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 48;
                end
                default:
                begin
                    tx_idle_pct  = 20;
                    rx_stall_pct = 20;
                end
            endcase
            tick_pct = $urandom_range(100, 40);
            edge_pct = $urandom_range(60, 5);
            if (phase == 2)
            begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    drain();
                send_item(random_item(tick_pct, edge_pct));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && cfg_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/fsrc_pkg.sv
design/fsrc_in_if.sv
design/fsrc_out_if.sv
design/fsrc_cfg.sv
design/fsrc_step.sv
design/fan_stall_restart_control.sv
tb/tb_fan_stall_restart_control.sv
